// ===== src/pas_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pas_pkg
// Shared widths, constants, codes and types of the preferential attachment
// sampler.
// ============================================================================
package pas_pkg;

    // Default sizing of the node table and of the pick set
    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_LINKS_DEF = 8;

    // Fixed field and state widths
    localparam int RAND_W     = 32;
    localparam int NODE_OUT_W = 10;
    localparam int DEG_W      = 10;
    localparam int TOTAL_W    = 16;
    localparam int LINKS_W    = 4;
    localparam int INIT_W     = 7;
    localparam int PROD_W     = RAND_W + TOTAL_W;
    localparam int THR_W      = TOTAL_W + 1;
    localparam int M_DATA_W   = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_LINKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT  = 1'b1;

    // Reset values of the configuration registers
    localparam logic [LINKS_W-1:0] LINKS_RST = 4'd3;
    localparam logic [INIT_W-1:0]  INIT_RST  = 7'd10;

    // Operation codes carried in s_tuser
    localparam logic OP_INIT = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // Result status codes carried in m_tuser
    localparam logic STAT_EDGE = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    // Saturation limits
    localparam logic [DEG_W-1:0]   DEG_MAX   = 10'd1023;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

    // Commands from the sequencer to the pick set
    typedef struct packed {
        logic clear;
        logic insert;
    } pick_ctrl_t;

endpackage

// ===== src/preferential_attachment_sampler.sv =====
`timescale 1ns / 1ps
// ============================================================================
// preferential_attachment_sampler
// Grows a graph by preferential attachment: seeds a complete graph, samples
// endpoints in proportion to degree and emits the new edges.
// ============================================================================
// One word is taken at a time; s_tready is high only while the sequencer is
// idle. An init word fills the degree table, one entry a cycle. A draw word
// walks the degree table through the single read port of the degree memory,
// one node a cycle. A draw marked last then closes the node, emits each edge
// with a read, then a read-modify-write of the endpoint's degree, and appends
// the node; a full table is reported instead and the picks are dropped. Each
// result waits in an output register, and the sequencer stalls while that
// register is still occupied.
module preferential_attachment_sampler #(
    parameter int MAX_NODES = pas_pkg::MAX_NODES_DEF,
    parameter int MAX_LINKS = pas_pkg::MAX_LINKS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pas_pkg::RAND_W-1:0]       s_tdata,   // [31:0] random_fraction
    input  logic                             s_tuser,   // [0] operation
    input  logic                             s_tlast,   // last_draw
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pas_pkg::M_DATA_W-1:0]     m_tdata,   // [9:0] old_node, [19:10] new_node
    output logic                             m_tuser,   // [0] status
    output logic                             m_tlast,   // last
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pas_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = NODE_W + 1;
    localparam int LCNT_W = $clog2(MAX_LINKS + 1);
    localparam int LIDX_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int CUM_W  = pas_pkg::DEG_W + CNT_W;
    localparam int CMP_W  = (CUM_W > pas_pkg::THR_W) ? CUM_W : pas_pkg::THR_W;
    localparam int DEG_W  = pas_pkg::DEG_W;
    localparam int TOT_W  = pas_pkg::TOTAL_W;
    localparam int OUT_W  = pas_pkg::NODE_OUT_W;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_FILL    = 10'b0000000010,
        ST_MUL     = 10'b0000000100,
        ST_THR     = 10'b0000001000,
        ST_WALK    = 10'b0000010000,
        ST_END     = 10'b0000100000,
        ST_FULL    = 10'b0001000000,
        ST_EMIT_RD = 10'b0010000000,
        ST_EMIT_WR = 10'b0100000000,
        ST_FINISH  = 10'b1000000000
    } state_t;

    // Control registers
    state_t                          state_reg, state_next;
    logic [pas_pkg::LINKS_W-1:0]     links_reg, links_next;
    logic [pas_pkg::INIT_W-1:0]      init_reg, init_next;
    logic [CNT_W-1:0]                node_count_reg, node_count_next;
    logic [TOT_W-1:0]                total_reg, total_next;
    logic [LCNT_W-1:0]               draws_reg, draws_next;
    logic                            out_valid_reg, out_valid_next;

    // Payload registers
    logic [pas_pkg::RAND_W-1:0]      r_reg, r_next;
    logic                            last_reg, last_next;
    logic [pas_pkg::INIT_W-1:0]      n_reg, n_next;
    logic [NODE_W-1:0]               fill_reg, fill_next;
    logic [pas_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [pas_pkg::THR_W-1:0]       thr_reg, thr_next;
    logic [CUM_W-1:0]                cum_reg, cum_next;
    logic [NODE_W-1:0]               walk_reg, walk_next;
    logic [LCNT_W-1:0]               link_idx_reg, link_idx_next;
    logic [OUT_W-1:0]                out_old_reg, out_old_next;
    logic [OUT_W-1:0]                out_new_reg, out_new_next;
    logic                            out_status_reg, out_status_next;
    logic                            out_last_reg, out_last_next;

    // Degree memory
    logic [DEG_W-1:0]                deg_mem [MAX_NODES];
    logic [DEG_W-1:0]                rdata_reg;
    logic [NODE_W-1:0]               mem_raddr;
    logic [NODE_W-1:0]               mem_waddr;
    logic [DEG_W-1:0]                mem_wdata;
    logic                            mem_we;

    // Pick set
    pas_pkg::pick_ctrl_t             pick_ctrl;
    logic [NODE_W-1:0]               pick_rd_node;
    logic [LCNT_W-1:0]               pick_count;

    // Datapath helpers
    logic                            s_accept;
    logic                            slot_free;
    logic [LCNT_W-1:0]               limit;
    logic [pas_pkg::INIT_W-1:0]      n_lo;
    logic [pas_pkg::INIT_W-1:0]      n_eff;
    logic [pas_pkg::INIT_W-1:0]      n_m1;
    logic [2*pas_pkg::INIT_W-1:0]    seed_total;
    logic [CUM_W-1:0]                cum_sum;
    logic                            walk_hit;
    logic                            walk_at_last;
    logic [TOT_W:0]                  tot_sum;
    logic [TOT_W-1:0]                tot_inc;
    logic [DEG_W-1:0]                deg_inc;
    logic                            link_last;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || m_tready;

    // Clamp the draw limit to [1, MAX_LINKS] and the seed size to [2, MAX_NODES]
    always_comb begin
        if (links_reg == '0) begin
            limit = LCNT_W'(1);
        end else if (int'(links_reg) > MAX_LINKS) begin
            limit = LCNT_W'(MAX_LINKS);
        end else begin
            limit = LCNT_W'(links_reg);
        end
        n_lo  = (init_reg < pas_pkg::INIT_W'(2)) ? pas_pkg::INIT_W'(2) : init_reg;
        n_eff = (int'(n_lo) > MAX_NODES) ? pas_pkg::INIT_W'(MAX_NODES) : n_lo;
    end

    // Shared arithmetic of the sequencer
    always_comb begin
        n_m1         = n_reg - pas_pkg::INIT_W'(1);
        seed_total   = (2*pas_pkg::INIT_W)'(n_reg) * (2*pas_pkg::INIT_W)'(n_m1);
        cum_sum      = cum_reg + CUM_W'(rdata_reg);
        walk_hit     = CMP_W'(thr_reg) <= CMP_W'(cum_sum);
        walk_at_last = CNT_W'(walk_reg) == (node_count_reg - CNT_W'(1));
        tot_sum      = {1'b0, total_reg} + (TOT_W + 1)'(2);
        tot_inc      = tot_sum[TOT_W] ? pas_pkg::TOTAL_MAX : tot_sum[TOT_W-1:0];
        deg_inc      = (rdata_reg < pas_pkg::DEG_MAX) ? rdata_reg + DEG_W'(1) : rdata_reg;
        link_last    = (link_idx_reg + LCNT_W'(1)) == pick_count;
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        links_next      = links_reg;
        init_next       = init_reg;
        node_count_next = node_count_reg;
        total_next      = total_reg;
        draws_next      = draws_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        r_next          = r_reg;
        last_next       = last_reg;
        n_next          = n_reg;
        fill_next       = fill_reg;
        prod_next       = prod_reg;
        thr_next        = thr_reg;
        cum_next        = cum_reg;
        walk_next       = walk_reg;
        link_idx_next   = link_idx_reg;
        out_old_next    = out_old_reg;
        out_new_next    = out_new_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        mem_raddr       = walk_reg;
        mem_waddr       = fill_reg;
        mem_wdata       = DEG_W'(n_m1);
        mem_we          = 1'b0;
        pick_ctrl       = '0;

        // Take configuration writes at any time
        if (cfg_valid) begin
            case (cfg_index)
                pas_pkg::CFG_LINKS: links_next = cfg_data[pas_pkg::LINKS_W-1:0];
                pas_pkg::CFG_INIT:  init_next  = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    r_next    = s_tdata;
                    last_next = s_tlast;
                    if (s_tuser == pas_pkg::OP_INIT) begin
                        n_next          = n_eff;
                        fill_next       = '0;
                        pick_ctrl.clear = 1'b1;
                        draws_next      = '0;
                        state_next      = ST_FILL;
                    end else if (node_count_reg == '0) begin
                        pick_ctrl.clear = 1'b1;
                        draws_next      = '0;
                    end else if (draws_reg < limit) begin
                        state_next = ST_MUL;
                    end else if (s_tlast) begin
                        state_next = ST_END;
                    end
                end
            end

            // Write the seed degree, one entry a cycle
            ST_FILL: begin
                mem_we = 1'b1;
                if (CMP_W'(fill_reg) == CMP_W'(n_m1)) begin
                    total_next      = TOT_W'(seed_total);
                    node_count_next = CNT_W'(n_reg);
                    state_next      = ST_IDLE;
                end else begin
                    fill_next = fill_reg + NODE_W'(1);
                end
            end

            // Scale the fraction by the degree total
            ST_MUL: begin
                prod_next  = pas_pkg::PROD_W'(r_reg) * pas_pkg::PROD_W'(total_reg);
                state_next = ST_THR;
            end

            // Round the target up to whole units and start the walk at node zero
            ST_THR: begin
                thr_next   = {1'b0, prod_reg[pas_pkg::PROD_W-1:pas_pkg::RAND_W]}
                           + pas_pkg::THR_W'(|prod_reg[pas_pkg::RAND_W-1:0]);
                mem_raddr  = '0;
                walk_next  = '0;
                cum_next   = '0;
                state_next = ST_WALK;
            end

            // Accumulate one degree a cycle until the running sum reaches the target or the walk reaches the last node
            ST_WALK: begin
                mem_raddr = walk_reg + NODE_W'(1);
                if (walk_hit || walk_at_last) begin
                    pick_ctrl.insert = 1'b1;
                    draws_next       = draws_reg + LCNT_W'(1);
                    state_next       = last_reg ? ST_END : ST_IDLE;
                end else begin
                    walk_next = walk_reg + NODE_W'(1);
                    cum_next  = cum_sum;
                end
            end

            ST_END: begin
                link_idx_next = '0;
                if (node_count_reg >= CNT_W'(MAX_NODES)) begin
                    state_next = ST_FULL;
                end else if (pick_count == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end

            // Report a full table and drop the picks
            ST_FULL: begin
                if (slot_free) begin
                    out_valid_next  = 1'b1;
                    out_old_next    = '0;
                    out_new_next    = '0;
                    out_status_next = pas_pkg::STAT_FULL;
                    out_last_next   = 1'b1;
                    pick_ctrl.clear = 1'b1;
                    draws_next      = '0;
                    state_next      = ST_IDLE;
                end
            end

            ST_EMIT_RD: begin
                mem_raddr  = pick_rd_node;
                state_next = ST_EMIT_WR;
            end

            // Emit one edge and bump the old endpoint's degree
            ST_EMIT_WR: begin
                mem_raddr = pick_rd_node;
                if (slot_free) begin
                    mem_we          = 1'b1;
                    mem_waddr       = pick_rd_node;
                    mem_wdata       = deg_inc;
                    total_next      = tot_inc;
                    out_valid_next  = 1'b1;
                    out_old_next    = OUT_W'(pick_rd_node);
                    out_new_next    = OUT_W'(node_count_reg);
                    out_status_next = pas_pkg::STAT_EDGE;
                    out_last_next   = link_last;
                    if (link_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        link_idx_next = link_idx_reg + LCNT_W'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end

            // Append the new node with one degree per edge
            ST_FINISH: begin
                mem_we          = 1'b1;
                mem_waddr       = node_count_reg[NODE_W-1:0];
                mem_wdata       = DEG_W'(pick_count);
                node_count_next = node_count_reg + CNT_W'(1);
                pick_ctrl.clear = 1'b1;
                draws_next      = '0;
                state_next      = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            links_reg      <= pas_pkg::LINKS_RST;
            init_reg       <= pas_pkg::INIT_RST;
            node_count_reg <= '0;
            total_reg      <= '0;
            draws_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            links_reg      <= links_next;
            init_reg       <= init_next;
            node_count_reg <= node_count_next;
            total_reg      <= total_next;
            draws_reg      <= draws_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        r_reg          <= r_next;
        last_reg       <= last_next;
        n_reg          <= n_next;
        fill_reg       <= fill_next;
        prod_reg       <= prod_next;
        thr_reg        <= thr_next;
        cum_reg        <= cum_next;
        walk_reg       <= walk_next;
        link_idx_reg   <= link_idx_next;
        out_old_reg    <= out_old_next;
        out_new_reg    <= out_new_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // Degree memory: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            deg_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= deg_mem[mem_raddr];
    end

    pas_pick_set #(
        .MAX_LINKS (MAX_LINKS),
        .NODE_W    (NODE_W)
    ) u_pick_set (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (pick_ctrl),
        .ins_node (walk_reg),
        .rd_idx   (link_idx_reg[LIDX_W-1:0]),
        .rd_node  (pick_rd_node),
        .count    (pick_count)
    );

    // Drive the result word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(pas_pkg::M_DATA_W - 2*OUT_W){1'b0}}, out_new_reg, out_old_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        node_count_reg <= CNT_W'(MAX_NODES))
        else $error("node count beyond table size");

    a_picks_vs_draws: assert property (@(posedge aclk) disable iff (!aresetn)
        pick_count <= draws_reg)
        else $error("more picks held than draws taken");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (CNT_W'(walk_reg) < node_count_reg))
        else $error("degree walk past the last node");

    a_full_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == pas_pkg::STAT_FULL)) |-> m_tlast)
        else $error("table full word not marked last");

endmodule

// ===== src/pas_pick_set.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pas_pick_set
// Sorted set of picked nodes without duplicates, with one read port.
// ============================================================================
module pas_pick_set #(
    parameter int MAX_LINKS = pas_pkg::MAX_LINKS_DEF,
    parameter int NODE_W    = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pas_pkg::pick_ctrl_t                 ctrl,
    input  logic [NODE_W-1:0]                   ins_node,
    input  logic [((MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1)-1:0] rd_idx,
    output logic [NODE_W-1:0]                   rd_node,
    output logic [$clog2(MAX_LINKS + 1)-1:0]    count
);

    localparam int LCNT_W = $clog2(MAX_LINKS + 1);

    logic [NODE_W-1:0]    set_reg  [MAX_LINKS];
    logic [NODE_W-1:0]    set_next [MAX_LINKS];
    logic [LCNT_W-1:0]    count_reg;
    logic [LCNT_W-1:0]    count_next;
    logic [MAX_LINKS-1:0] lt;
    logic [MAX_LINKS-1:0] eq;
    logic                 do_ins;

    // Compare the new node against every held entry; the smaller ones form a prefix
    always_comb begin
        for (int k = 0; k < MAX_LINKS; k++) begin
            lt[k] = (count_reg > LCNT_W'(k)) && (set_reg[k] < ins_node);
            eq[k] = (count_reg > LCNT_W'(k)) && (set_reg[k] == ins_node);
        end
        do_ins = ctrl.insert && !(|eq) && (count_reg < LCNT_W'(MAX_LINKS));
    end

    // Shift the tail up by one and drop the new node into its slot
    always_comb begin
        set_next[0] = lt[0] ? set_reg[0] : ins_node;
        for (int k = 1; k < MAX_LINKS; k++) begin
            if (lt[k]) begin
                set_next[k] = set_reg[k];
            end else if (lt[k-1]) begin
                set_next[k] = ins_node;
            end else begin
                set_next[k] = set_reg[k-1];
            end
        end
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (do_ins) begin
            count_next = count_reg + LCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_ins) begin
            for (int k = 0; k < MAX_LINKS; k++) begin
                set_reg[k] <= set_next[k];
            end
        end
    end

    assign rd_node = set_reg[rd_idx];
    assign count   = count_reg;

endmodule
